// ===== src/swhs_pkg.sv =====
package swhs_pkg;

    // Width of the configuration write data and of the register index.
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    // Bit counter width; the frame never exceeds 64 bits.
    localparam int BIT_IDX_W = 6;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd3;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] RST_IDLE      = 20'd100000;
    localparam logic [CFG_DATA_W-1:0] RST_START_LOW = 20'd18000;
    localparam logic [CFG_DATA_W-1:0] RST_RELEASE   = 20'd40;
    localparam logic [CFG_DATA_W-1:0] RST_TIMEOUT   = 20'd1000;

    // Width of the release register.
    localparam int RELEASE_W = 10;

    // Phases of a read.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_START,
        PH_REL,
        PH_RLOW,
        PH_RHIGH,
        PH_BLOW,
        PH_BHIGH
    } t_phase;

    // Completion codes of a read.
    typedef enum logic [1:0] {
        ST_OK,
        ST_TIMEOUT,
        ST_CHECKSUM
    } t_status;

    // One result item.
    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        t_status    status;
        logic [7:0] humidity;
        logic [7:0] humidity_frac;
        logic [7:0] temperature;
        logic [7:0] temperature_frac;
        logic [7:0] check_byte;
    } t_result;

endpackage

// ===== src/swhs_cfg.sv =====
module swhs_cfg #(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [swhs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [swhs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [COUNT_WIDTH-1:0]             o_idle_lim,
    output logic [COUNT_WIDTH-1:0]             o_start_lim,
    output logic [COUNT_WIDTH-1:0]             o_release_lim,
    output logic [COUNT_WIDTH-1:0]             o_timeout_lim
);

    localparam int XW = (COUNT_WIDTH > swhs_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                             : swhs_pkg::CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_idle;
    logic [COUNT_WIDTH-1:0] r_start;
    logic [COUNT_WIDTH-1:0] r_release;
    logic [COUNT_WIDTH-1:0] r_timeout;
    logic [swhs_pkg::CFG_DATA_W-1:0] release_data;

    // Clamp a register value to the largest count the counters can hold.
    function automatic logic [COUNT_WIDTH-1:0] lim(input logic [swhs_pkg::CFG_DATA_W-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        if (vx > XW'(CNT_MAX)) begin
            lim = CNT_MAX;
        end else begin
            lim = COUNT_WIDTH'(vx);
        end
    endfunction

    // The release register is ten bits wide; upper data bits are dropped.
    assign release_data = swhs_pkg::CFG_DATA_W'(i_cfg_data[swhs_pkg::RELEASE_W-1:0]);

    // Limits are stored already clamped, so the counters compare directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle    <= lim(swhs_pkg::RST_IDLE);
            r_start   <= lim(swhs_pkg::RST_START_LOW);
            r_release <= lim(swhs_pkg::RST_RELEASE);
            r_timeout <= lim(swhs_pkg::RST_TIMEOUT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swhs_pkg::CFG_IDLE:      r_idle    <= lim(i_cfg_data);
                swhs_pkg::CFG_START_LOW: r_start   <= lim(i_cfg_data);
                swhs_pkg::CFG_RELEASE:   r_release <= lim(release_data);
                swhs_pkg::CFG_TIMEOUT:   r_timeout <= lim(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_idle_lim    = r_idle;
    assign o_start_lim   = r_start;
    assign o_release_lim = r_release;
    assign o_timeout_lim = r_timeout;

endmodule

// ===== src/swhs_fsm.sv =====
module swhs_fsm #(
    parameter int FRAME_BITS  = 40,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_act,
    input  logic                    i_lvl,
    input  logic [COUNT_WIDTH-1:0]  i_idle_lim,
    input  logic [COUNT_WIDTH-1:0]  i_start_lim,
    input  logic [COUNT_WIDTH-1:0]  i_release_lim,
    input  logic [COUNT_WIDTH-1:0]  i_timeout_lim,
    output swhs_pkg::t_result       o_result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam int VIEW_W = (FRAME_BITS > 40) ? FRAME_BITS : 40;
    localparam int BCMP_W = swhs_pkg::BIT_IDX_W + 1;

    swhs_pkg::t_phase  r_phase, n_phase;
    swhs_pkg::t_status r_status, n_status;
    logic [COUNT_WIDTH-1:0] r_wait, n_wait;
    logic [COUNT_WIDTH-1:0] r_low, n_low;
    logic [swhs_pkg::BIT_IDX_W-1:0] r_bit, n_bit;
    logic [FRAME_BITS-1:0] r_shift, n_shift;

    logic [COUNT_WIDTH-1:0] w_inc;
    logic [COUNT_WIDTH-1:0] w_step;
    logic [COUNT_WIDTH-1:0] lim_sel;
    logic                   lim_hit;
    logic [swhs_pkg::BIT_IDX_W-1:0] bit_nx;
    logic                   bit_end;
    logic                   sum_ok;
    logic                   done;
    logic [VIEW_W-1:0]      view;
    logic [7:0]             sum;

    // Saturating tick count and the next bit number.
    assign w_inc  = (r_wait == CNT_MAX) ? r_wait : r_wait + CNT_ONE;
    assign bit_nx = r_bit + swhs_pkg::BIT_IDX_W'(1);

    // Limit of the current fixed-length wait.
    always_comb begin
        case (r_phase)
            swhs_pkg::PH_PRE:   lim_sel = i_idle_lim;
            swhs_pkg::PH_START: lim_sel = i_start_lim;
            default:            lim_sel = i_release_lim;
        endcase
    end

    // Counters and frame shift register.
    always_comb begin
        w_step  = r_wait;
        n_low   = r_low;
        n_bit   = r_bit;
        n_shift = r_shift;
        bit_end = 1'b0;
        lim_hit = 1'b0;
        case (r_phase)
            swhs_pkg::PH_IDLE: begin
                if (i_act) begin
                    w_step  = '0;
                    n_low   = '0;
                    n_bit   = '0;
                    n_shift = '0;
                end
            end
            swhs_pkg::PH_PRE, swhs_pkg::PH_START, swhs_pkg::PH_REL: begin
                lim_hit = (w_inc >= lim_sel);
                w_step  = lim_hit ? '0 : w_inc;
            end
            swhs_pkg::PH_RLOW, swhs_pkg::PH_BLOW: begin
                if (!i_lvl) begin
                    w_step = w_inc;
                end else begin
                    if (r_phase == swhs_pkg::PH_BLOW) begin
                        n_low = r_wait;
                    end
                    w_step = CNT_ONE;
                end
            end
            swhs_pkg::PH_RHIGH: begin
                w_step = i_lvl ? w_inc : CNT_ONE;
            end
            swhs_pkg::PH_BHIGH: begin
                if (i_lvl) begin
                    w_step = w_inc;
                end else begin
                    // A bit is one when its high pulse outlasts its low pulse.
                    n_shift = {r_shift[FRAME_BITS-2:0], (r_wait > r_low)};
                    n_bit   = bit_nx;
                    bit_end = (BCMP_W'(bit_nx) >= BCMP_W'(FRAME_BITS)) ||
                              (bit_nx == '0);
                    w_step  = CNT_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Byte view of the frame and the checksum over the four data bytes.
    assign view   = VIEW_W'(n_shift);
    assign sum    = view[15:8] + view[23:16] + view[31:24] + view[39:32];
    assign sum_ok = (sum == view[7:0]);

    // Next phase, completion and status.
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        done     = 1'b0;
        case (r_phase)
            swhs_pkg::PH_IDLE: begin
                if (i_act) begin
                    n_phase = swhs_pkg::PH_PRE;
                end
            end
            swhs_pkg::PH_PRE: begin
                if (lim_hit) begin
                    n_phase = swhs_pkg::PH_START;
                end
            end
            swhs_pkg::PH_START: begin
                if (lim_hit) begin
                    n_phase = swhs_pkg::PH_REL;
                end
            end
            swhs_pkg::PH_REL: begin
                if (lim_hit) begin
                    n_phase = swhs_pkg::PH_RLOW;
                end
            end
            swhs_pkg::PH_RLOW: begin
                if (i_lvl) begin
                    n_phase = swhs_pkg::PH_RHIGH;
                end
                if (w_step >= i_timeout_lim) begin
                    done     = 1'b1;
                    n_status = swhs_pkg::ST_TIMEOUT;
                end
            end
            swhs_pkg::PH_BLOW: begin
                if (i_lvl) begin
                    n_phase = swhs_pkg::PH_BHIGH;
                end
                if (w_step >= i_timeout_lim) begin
                    done     = 1'b1;
                    n_status = swhs_pkg::ST_TIMEOUT;
                end
            end
            swhs_pkg::PH_RHIGH: begin
                if (!i_lvl) begin
                    n_phase = swhs_pkg::PH_BLOW;
                end
                if (w_step >= i_timeout_lim) begin
                    done     = 1'b1;
                    n_status = swhs_pkg::ST_TIMEOUT;
                end
            end
            swhs_pkg::PH_BHIGH: begin
                if (!i_lvl && bit_end) begin
                    done     = 1'b1;
                    n_status = sum_ok ? swhs_pkg::ST_OK : swhs_pkg::ST_CHECKSUM;
                end else begin
                    if (!i_lvl) begin
                        n_phase = swhs_pkg::PH_BLOW;
                    end
                    if (w_step >= i_timeout_lim) begin
                        done     = 1'b1;
                        n_status = swhs_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
                n_phase = swhs_pkg::PH_IDLE;
            end
        endcase
        if (done) begin
            n_phase = swhs_pkg::PH_IDLE;
        end
    end

    assign n_wait = done ? '0 : w_step;

    // Result fields reflect the state after this tick's update.
    always_comb begin
        o_result.drive_low        = (n_phase == swhs_pkg::PH_START);
        o_result.busy             = (n_phase != swhs_pkg::PH_IDLE);
        o_result.done             = done;
        o_result.status           = n_status;
        o_result.humidity         = view[39:32];
        o_result.humidity_frac    = view[31:24];
        o_result.temperature      = view[23:16];
        o_result.temperature_frac = view[15:8];
        o_result.check_byte       = view[7:0];
    end

    // State advances once per tick that moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= swhs_pkg::PH_IDLE;
            r_status <= swhs_pkg::ST_OK;
            r_wait   <= '0;
            r_low    <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_wait   <= n_wait;
            r_low    <= n_low;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
        end
    end

`ifndef SYNTH
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |=> (r_phase == swhs_pkg::PH_IDLE && r_wait == '0))
        else $error("read finished but phase did not return to idle");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == swhs_pkg::PH_IDLE && !i_act) |=>
        (r_phase == swhs_pkg::PH_IDLE))
        else $error("idle phase left without a start request");

    a_no_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_wait) && $stable(r_shift)))
        else $error("state changed without a tick");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (BCMP_W'(r_bit) <= BCMP_W'(FRAME_BITS)))
        else $error("bit counter beyond frame length");
`endif

endmodule

// ===== src/single_wire_humidity_sensor_reader.sv =====
// Single-wire temperature and humidity sensor reader.
// Each input transaction is one tick: i_action requests a read and
// i_line_level carries the sampled data line. Each input transaction
// yields exactly one output transaction with the line drive, busy and
// done flags, the last read status and the five frame bytes.
// A read releases the line for idle_ticks, drives it low for
// start_low_ticks, releases it for release_ticks, then times the sensor's
// response and 40 bit pulses; any level wait reaching timeout_ticks ends
// it with a timeout status, and a bad check byte with a checksum status.
// Configuration is written on i_cfg_we with i_cfg_index and i_cfg_data.
// Pipeline: an input transaction is registered, then its result is loaded
// into the output register; one transaction per cycle is sustained while
// the receiver is ready, as the read state machine is combinational between them.
// When the receiver stalls, the output register holds its result and the
// input register holds one more tick; o_in_ready then drops.
// Reset is synchronous and active low: the block returns to idle with
// cleared counters, frame and status, and registers take their defaults.
module single_wire_humidity_sensor_reader #(
    parameter int FRAME_BITS  = 40,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swhs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swhs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic                             i_line_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_drive_low,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_humidity,
    output logic [7:0]                       o_humidity_frac,
    output logic [7:0]                       o_temperature,
    output logic [7:0]                       o_temperature_frac,
    output logic [7:0]                       o_check_byte
);

    logic [COUNT_WIDTH-1:0] idle_lim;
    logic [COUNT_WIDTH-1:0] start_lim;
    logic [COUNT_WIDTH-1:0] release_lim;
    logic [COUNT_WIDTH-1:0] timeout_lim;

    logic r_in_valid;
    logic r_act;
    logic r_lvl;
    logic r_out_valid;
    swhs_pkg::t_result r_out;
    swhs_pkg::t_result result;
    logic step;

    swhs_cfg #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_idle_lim    (idle_lim),
        .o_start_lim   (start_lim),
        .o_release_lim (release_lim),
        .o_timeout_lim (timeout_lim)
    );

    // A registered tick moves on whenever the output register is free.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    swhs_fsm #(
        .FRAME_BITS  (FRAME_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_act         (r_act),
        .i_lvl         (r_lvl),
        .i_idle_lim    (idle_lim),
        .i_start_lim   (start_lim),
        .i_release_lim (release_lim),
        .i_timeout_lim (timeout_lim),
        .o_result      (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_act <= i_action;
            r_lvl <= i_line_level;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_drive_low        = r_out.drive_low;
    assign o_busy_res         = r_out.busy;
    assign o_done_res         = r_out.done;
    assign o_status           = r_out.status;
    assign o_humidity         = r_out.humidity;
    assign o_humidity_frac    = r_out.humidity_frac;
    assign o_temperature      = r_out.temperature;
    assign o_temperature_frac = r_out.temperature_frac;
    assign o_check_byte       = r_out.check_byte;

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    a_step_needs_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> r_in_valid)
        else $error("state advanced without a registered tick");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both registers are full");
`endif

endmodule

// ===== bench/single_wire_humidity_sensor_reader_tb.sv =====
`timescale 1ns / 100ps

module single_wire_humidity_sensor_reader_tb;

    localparam int FRAME_LEN = 40;
    localparam logic [19:0] COUNT_TOP = 20'hFFFFF;

    // Clock, reset and the inputs of the block, all known from time zero.
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [swhs_pkg::CFG_INDEX_W-1:0] i_cfg_index = swhs_pkg::CFG_IDLE;
    logic [swhs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             i_action = 1'b0;
    logic                             i_line_level = 1'b0;
    logic                             i_out_ready = 1'b1;

    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_drive_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic [1:0] o_status;
    logic [7:0] o_humidity;
    logic [7:0] o_humidity_frac;
    logic [7:0] o_temperature;
    logic [7:0] o_temperature_frac;
    logic [7:0] o_check_byte;

    // Timing registers and read state as the bench believes them to be.
    logic [19:0]       cfg_idle;
    logic [19:0]       cfg_start_low;
    logic [9:0]        cfg_release;
    logic [19:0]       cfg_timeout;
    swhs_pkg::t_phase  rd_phase;
    logic [19:0]       rd_wait;
    logic [19:0]       rd_low;
    logic [5:0]        rd_bits;
    logic [39:0]       rd_frame;
    swhs_pkg::t_status rd_status;

    // Readings still owed by the block, oldest first.
    swhs_pkg::t_result pending_readings[$];
    swhs_pkg::t_result oldest;

    int mismatches = 0;
    int ticks_total = 0;
    int work_ticks = 0;
    int timing_sets = 0;
    int reads_ok = 0;
    int reads_timed_out = 0;
    int reads_bad_check = 0;
    int burst_left = 0;
    int gap = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_step = 0;
    logic [8:0] stall_pattern = 9'b101101110;

    single_wire_humidity_sensor_reader uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_line_level       (i_line_level),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_drive_low        (o_drive_low),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_status           (o_status),
        .o_humidity         (o_humidity),
        .o_humidity_frac    (o_humidity_frac),
        .o_temperature      (o_temperature),
        .o_temperature_frac (o_temperature_frac),
        .o_check_byte       (o_check_byte)
    );

    // A 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Saturating tick counter, as wide as the block's counters.
    function automatic logic [19:0] count_up(input logic [19:0] c);
        return (c == COUNT_TOP) ? c : c + 20'd1;
    endfunction

    // Builds a frame from four data bytes, with a correct or a corrupted check byte.
    function automatic logic [39:0] make_frame(input logic [31:0] data, input logic good);
        logic [7:0] sum;
        sum = data[31:24] + data[23:16] + data[15:8] + data[7:0];
        if (!good) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        return {data, sum};
    endfunction

    // Advances the read state by one tick and gives the reading the block should show.
    task automatic predict_tick(input logic act, input logic lvl,
                                output swhs_pkg::t_result r);
        logic       fin;
        logic [7:0] sum;
        fin = 1'b0;
        case (rd_phase)
            swhs_pkg::PH_IDLE: begin
                if (act) begin
                    rd_phase = swhs_pkg::PH_PRE;
                    rd_wait  = '0;
                    rd_low   = '0;
                    rd_bits  = '0;
                    rd_frame = '0;
                end
            end
            swhs_pkg::PH_PRE: begin
                rd_wait = count_up(rd_wait);
                if (rd_wait >= cfg_idle) begin
                    rd_phase = swhs_pkg::PH_START;
                    rd_wait  = '0;
                end
            end
            swhs_pkg::PH_START: begin
                rd_wait = count_up(rd_wait);
                if (rd_wait >= cfg_start_low) begin
                    rd_phase = swhs_pkg::PH_REL;
                    rd_wait  = '0;
                end
            end
            swhs_pkg::PH_REL: begin
                rd_wait = count_up(rd_wait);
                if (rd_wait >= {10'd0, cfg_release}) begin
                    rd_phase = swhs_pkg::PH_RLOW;
                    rd_wait  = '0;
                end
            end
            swhs_pkg::PH_RLOW, swhs_pkg::PH_BLOW: begin
                if (!lvl) begin
                    rd_wait = count_up(rd_wait);
                end else begin
                    if (rd_phase == swhs_pkg::PH_BLOW) begin
                        rd_low   = rd_wait;
                        rd_phase = swhs_pkg::PH_BHIGH;
                    end else begin
                        rd_phase = swhs_pkg::PH_RHIGH;
                    end
                    rd_wait = 20'd1;
                end
                if (rd_wait >= cfg_timeout) begin
                    fin       = 1'b1;
                    rd_status = swhs_pkg::ST_TIMEOUT;
                end
            end
            swhs_pkg::PH_RHIGH, swhs_pkg::PH_BHIGH: begin
                if (lvl) begin
                    rd_wait = count_up(rd_wait);
                    if (rd_wait >= cfg_timeout) begin
                        fin       = 1'b1;
                        rd_status = swhs_pkg::ST_TIMEOUT;
                    end
                end else if (rd_phase == swhs_pkg::PH_RHIGH) begin
                    rd_phase = swhs_pkg::PH_BLOW;
                    rd_wait  = 20'd1;
                    if (rd_wait >= cfg_timeout) begin
                        fin       = 1'b1;
                        rd_status = swhs_pkg::ST_TIMEOUT;
                    end
                end else begin
                    // A falling edge closes a bit: it is 1 when the high pulse was longer.
                    rd_frame = {rd_frame[38:0], (rd_wait > rd_low)};
                    rd_bits  = rd_bits + 6'd1;
                    if (rd_bits >= FRAME_LEN || rd_bits == 0) begin
                        sum = rd_frame[39:32] + rd_frame[31:24] + rd_frame[23:16]
                            + rd_frame[15:8];
                        fin = 1'b1;
                        rd_status = (sum == rd_frame[7:0]) ? swhs_pkg::ST_OK
                                                           : swhs_pkg::ST_CHECKSUM;
                    end else begin
                        rd_phase = swhs_pkg::PH_BLOW;
                        rd_wait  = 20'd1;
                        if (rd_wait >= cfg_timeout) begin
                            fin       = 1'b1;
                            rd_status = swhs_pkg::ST_TIMEOUT;
                        end
                    end
                end
            end
            default: rd_phase = swhs_pkg::PH_IDLE;
        endcase

        if (fin) begin
            rd_phase = swhs_pkg::PH_IDLE;
            rd_wait  = '0;
            case (rd_status)
                swhs_pkg::ST_OK:      reads_ok++;
                swhs_pkg::ST_TIMEOUT: reads_timed_out++;
                default:              reads_bad_check++;
            endcase
        end

        r.drive_low        = (rd_phase == swhs_pkg::PH_START);
        r.busy             = (rd_phase != swhs_pkg::PH_IDLE);
        r.done             = fin;
        r.status           = rd_status;
        r.humidity         = rd_frame[39:32];
        r.humidity_frac    = rd_frame[31:24];
        r.temperature      = rd_frame[23:16];
        r.temperature_frac = rd_frame[15:8];
        r.check_byte       = rd_frame[7:0];
    endtask

    // Sends one tick; the sender works in bursts with random gaps between them.
    task automatic send_tick(input logic act, input logic lvl);
        swhs_pkg::t_result r;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_line_level <= lvl;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        ticks_total++;
        if (act || rd_phase != swhs_pkg::PH_IDLE) begin
            work_ticks++;
        end
        predict_tick(act, lvl, r);
        pending_readings.push_back(r);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every owed reading has come out.
    task automatic settle_reader();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    // Writes all four timing registers while the block is idle.
    task automatic load_timing(input logic [19:0] idle_v, input logic [19:0] start_v,
                               input logic [19:0] rel_v, input logic [19:0] tmo_v);
        settle_reader();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= swhs_pkg::CFG_IDLE;
        i_cfg_data  <= idle_v;
        @(negedge i_clk);
        i_cfg_index <= swhs_pkg::CFG_START_LOW;
        i_cfg_data  <= start_v;
        @(negedge i_clk);
        i_cfg_index <= swhs_pkg::CFG_RELEASE;
        i_cfg_data  <= rel_v;
        @(negedge i_clk);
        i_cfg_index <= swhs_pkg::CFG_TIMEOUT;
        i_cfg_data  <= tmo_v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_idle      = idle_v;
        cfg_start_low = start_v;
        cfg_release   = rel_v[swhs_pkg::RELEASE_W-1:0];
        cfg_timeout   = tmo_v;
        timing_sets++;
    endtask

    // Keeps ticking at one line level until the read has ended.
    task automatic finish_read(input logic lvl);
        while (rd_phase != swhs_pkg::PH_IDLE) begin
            send_tick(1'b0, lvl);
        end
    endtask

    // Starts a read and plays a sensor answer carrying the frame. A non-negative
    // cut truncates the answer after that many ticks, leaving the line stuck.
    task automatic read_frame(input logic [39:0] frame, input int cut);
        bit wave[$];
        int pulse_max;
        int lo;
        int hi;
        int k;
        int pause_at;
        if (cfg_timeout > 4) begin
            pulse_max = 3;
        end else if (cfg_timeout > 2) begin
            pulse_max = int'(cfg_timeout) - 1;
        end else begin
            pulse_max = 2;
        end
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        // Start requests while busy are ignored; the line is not looked at yet.
        while (rd_phase == swhs_pkg::PH_PRE || rd_phase == swhs_pkg::PH_START ||
               rd_phase == swhs_pkg::PH_REL) begin
            send_tick(1'($urandom_range(0, 15) == 0), 1'($urandom_range(0, 1)));
        end
        // Response low and high pulses, then one low/high pair per bit.
        repeat ($urandom_range(1, pulse_max)) wave.push_back(1'b0);
        repeat ($urandom_range(1, pulse_max)) wave.push_back(1'b1);
        for (int i = FRAME_LEN - 1; i >= 0; i--) begin
            if (frame[i]) begin
                lo = $urandom_range(1, pulse_max - 1);
                hi = $urandom_range(lo + 1, pulse_max);
            end else begin
                lo = $urandom_range(1, pulse_max);
                hi = $urandom_range(1, lo);
            end
            repeat (lo) wave.push_back(1'b0);
            repeat (hi) wave.push_back(1'b1);
        end
        wave.push_back(1'b0);
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, wave.size() - 1) : -1;
        k = 0;
        while (k < wave.size() && (cut < 0 || k < cut) && rd_phase != swhs_pkg::PH_IDLE) begin
            if (k == pause_at) begin
                settle_reader();
            end
            send_tick(1'b0, wave[k]);
            k++;
        end
        finish_read(1'($urandom_range(0, 1)));
    endtask

    // The line is ignored while no read is running.
    task automatic test_idle_line();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        settle_reader();
    endtask

    // Zero waits act as one tick, a second start is ignored, a low wait times out.
    task automatic test_zero_registers();
        load_timing(20'd0, 20'd0, 20'd0, 20'd2);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        finish_read(1'b0);
    endtask

    // Passes the response, starts a bit and times out on its high pulse.
    task automatic test_wait_timeouts();
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        finish_read(1'b1);
    endtask

    // Upper data bits of the release register are dropped; a zero timeout ends at once.
    task automatic test_register_masking();
        load_timing(20'd1, 20'd1, 20'hFFC01, 20'd0);
        send_tick(1'b1, 1'b1);
        repeat (3) send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        finish_read(1'b0);
    endtask

    // Whole frames of all ones and of all zeros with a bad check byte, then minimum timings.
    task automatic test_frame_extremes();
        load_timing(20'd1, 20'd2, 20'd1, 20'd9);
        read_frame(make_frame(32'hFFFF_FFFF, 1'b1), -1);
        read_frame({32'h0000_0000, 8'hFF}, -1);
        load_timing(20'd1, 20'd1, 20'd1, 20'd1);
        read_frame(make_frame(32'hA55A_0FF0, 1'b1), -1);
    endtask

    // Longer waits and the largest timeout; short timings return afterwards so that
    // a stuck line ends a read quickly.
    task automatic test_long_timings();
        load_timing(20'd40, 20'd40, 20'd40, COUNT_TOP);
        read_frame(make_frame($urandom, 1'b1), -1);
        load_timing(20'd2, 20'd3, 20'd2, 20'd9);
    endtask

    // Mostly well-formed reads with random content, some cut short, some noise.
    task automatic test_random_traffic();
        int kind;
        int n;
        while (ticks_total < 700) begin
            if ($urandom_range(0, 2) == 0) begin
                load_timing(20'($urandom_range(0, 6)), 20'($urandom_range(0, 6)),
                            20'($urandom_range(0, 4) | ($urandom_range(0, 1023) << 10)),
                            ($urandom_range(0, 5) == 0) ? 20'($urandom_range(0, 3))
                                                        : 20'($urandom_range(7, 14)));
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                read_frame(make_frame($urandom, 1'($urandom_range(0, 3) != 0)), -1);
            end else if (kind == 7) begin
                read_frame(make_frame($urandom, 1'b1), $urandom_range(0, 120));
            end else if (kind == 8) begin
                n = $urandom_range(5, 40);
                repeat (n) send_tick(1'($urandom_range(0, 5) == 0), 1'($urandom_range(0, 1)));
                finish_read(1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) begin
                settle_reader();
            end
        end
    endtask

    // The receiver stalls on patterns that change every so often.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left--;
        end
        stall_step = (stall_step + 1) % 9;
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= stall_pattern[stall_step];
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Prints one line for a mismatch and counts it.
    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < 40) begin
            $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Each output transaction is checked against the oldest owed reading.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                flag_mismatch("unexpected reading, drive_low", o_drive_low, 0);
            end else begin
                oldest = pending_readings.pop_front();
                if (o_drive_low !== oldest.drive_low)
                    flag_mismatch("drive_low", o_drive_low, oldest.drive_low);
                if (o_busy_res !== oldest.busy)
                    flag_mismatch("busy", o_busy_res, oldest.busy);
                if (o_done_res !== oldest.done)
                    flag_mismatch("done", o_done_res, oldest.done);
                if (o_status !== oldest.status)
                    flag_mismatch("status", o_status, oldest.status);
                if (o_humidity !== oldest.humidity)
                    flag_mismatch("humidity", o_humidity, oldest.humidity);
                if (o_humidity_frac !== oldest.humidity_frac)
                    flag_mismatch("humidity_frac", o_humidity_frac, oldest.humidity_frac);
                if (o_temperature !== oldest.temperature)
                    flag_mismatch("temperature", o_temperature, oldest.temperature);
                if (o_temperature_frac !== oldest.temperature_frac)
                    flag_mismatch("temperature_frac", o_temperature_frac,
                                  oldest.temperature_frac);
                if (o_check_byte !== oldest.check_byte)
                    flag_mismatch("check_byte", o_check_byte, oldest.check_byte);
            end
        end
    end

    // Ends a run that has stopped making progress.
    initial begin
        #4_000_000;
        $display("Run did not finish in time; %0d readings still owed.",
                 pending_readings.size());
        $display("** single_wire_humidity_sensor_reader: FAILED **");
        $finish;
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        cfg_idle      = swhs_pkg::RST_IDLE;
        cfg_start_low = swhs_pkg::RST_START_LOW;
        cfg_release   = swhs_pkg::RST_RELEASE[swhs_pkg::RELEASE_W-1:0];
        cfg_timeout   = swhs_pkg::RST_TIMEOUT;
        rd_phase      = swhs_pkg::PH_IDLE;
        rd_wait       = '0;
        rd_low        = '0;
        rd_bits       = '0;
        rd_frame      = '0;
        rd_status     = swhs_pkg::ST_OK;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_line();
        test_zero_registers();
        test_wait_timeouts();
        test_register_masking();
        test_frame_extremes();
        test_long_timings();
        test_random_traffic();

        settle_reader();
        repeat (8) @(negedge i_clk);
        $display("Covered %0d ticks, %0d of them inside reads, over %0d timing settings.",
                 ticks_total, work_ticks, timing_sets);
        $display("Reads ended: %0d ok, %0d timed out, %0d with a bad check byte.",
                 reads_ok, reads_timed_out, reads_bad_check);
        if (mismatches == 0) begin
            $display("** single_wire_humidity_sensor_reader: PASSED **");
        end else begin
            $display("** single_wire_humidity_sensor_reader: FAILED **");
        end
        $finish;
    end

endmodule
